### src/cbr_pkg.sv
package cbr_pkg;

    localparam int BLOCK_BYTES = 128;
    localparam int IDX_W       = $clog2(BLOCK_BYTES);
    localparam int WORDS       = BLOCK_BYTES / 2;
    localparam int WIDX_W      = (WORDS > 1) ? $clog2(WORDS) : 1;

    localparam int ADDR_W = 24;
    localparam int DATA_W = 16;
    localparam int SUM_W  = 16;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Register indexes (byte address / 4).
    localparam logic [1:0] REG_BASE_ADDRESS = 2'd0;
    localparam logic [1:0] REG_DATA_COMMAND = 2'd1;
    localparam logic [1:0] REG_STOP_COMMAND = 2'd2;

    localparam logic [ADDR_W-1:0] BASE_ADDRESS_RESET = '0;
    localparam logic [7:0]        DATA_COMMAND_RESET = 8'h01;
    localparam logic [7:0]        STOP_COMMAND_RESET = 8'h02;

    // Reply codes.
    localparam logic [1:0] REPLY_NONE = 2'd0;
    localparam logic [1:0] REPLY_ACK  = 2'd1;
    localparam logic [1:0] REPLY_NAK  = 2'd2;

    // Status codes.
    localparam logic [1:0] STATUS_LOADING = 2'd0;
    localparam logic [1:0] STATUS_OK      = 2'd1;
    localparam logic [1:0] STATUS_ERROR   = 2'd2;

    typedef struct packed {
        logic [ADDR_W-1:0] base_address;
        logic [7:0]        data_command;
        logic [7:0]        stop_command;
        logic              rearm;
    } cfg_t;

    typedef struct packed {
        logic       open_block;
        logic       store_data;
        logic       store_cklo;
        logic       close_block;
        logic       start_drain;
        logic       rd_en;
        logic       emit_single;
        logic       emit_word;
        logic [1:0] single_reply;
        logic [1:0] single_status;
    } cmd_t;

    typedef struct packed {
        logic data_match;
        logic stop_match;
        logic data_last;
        logic ck_match;
        logic drain_last;
        logic out_free;
    } stat_t;

endpackage

### src/cbr_regs.sv
module cbr_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cbr_pkg::PADDR_W-1:0] paddr,
    input  logic [cbr_pkg::PDATA_W-1:0] pwdata,
    output logic [cbr_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output cbr_pkg::cfg_t               cfg
);

    logic [cbr_pkg::ADDR_W-1:0] base_address_reg;
    logic [7:0]                 data_command_reg;
    logic [7:0]                 stop_command_reg;
    logic                       wr_en;
    logic [1:0]                 reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_address_reg <= cbr_pkg::BASE_ADDRESS_RESET;
            data_command_reg <= cbr_pkg::DATA_COMMAND_RESET;
            stop_command_reg <= cbr_pkg::STOP_COMMAND_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                cbr_pkg::REG_BASE_ADDRESS: base_address_reg <= pwdata[cbr_pkg::ADDR_W-1:0];
                cbr_pkg::REG_DATA_COMMAND: data_command_reg <= pwdata[7:0];
                cbr_pkg::REG_STOP_COMMAND: stop_command_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            cbr_pkg::REG_BASE_ADDRESS:
                prdata = {{(cbr_pkg::PDATA_W-cbr_pkg::ADDR_W){1'b0}}, base_address_reg};
            cbr_pkg::REG_DATA_COMMAND: prdata = {24'd0, data_command_reg};
            cbr_pkg::REG_STOP_COMMAND: prdata = {24'd0, stop_command_reg};
            default:                   prdata = '0;
        endcase
    end

    // The new base address takes effect in the same cycle as the re-arm.
    always_comb
    begin
        cfg.base_address = (wr_en && reg_idx == cbr_pkg::REG_BASE_ADDRESS)
                         ? pwdata[cbr_pkg::ADDR_W-1:0] : base_address_reg;
        cfg.data_command = data_command_reg;
        cfg.stop_command = stop_command_reg;
        cfg.rearm        = wr_en && reg_idx == cbr_pkg::REG_BASE_ADDRESS;
    end

endmodule

### src/cbr_datapath.sv
module cbr_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  cbr_pkg::cfg_t              cfg,
    input  cbr_pkg::cmd_t              cmd,
    output cbr_pkg::stat_t             stat,
    input  logic [7:0]                 rx_byte,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [1:0]                 reply,
    output logic                       write_valid,
    output logic [cbr_pkg::ADDR_W-1:0] write_address,
    output logic [cbr_pkg::DATA_W-1:0] write_data,
    output logic [1:0]                 status,
    output logic                       last
);

    logic [cbr_pkg::IDX_W-1:0]  byte_index_reg;
    logic [cbr_pkg::SUM_W-1:0]  running_sum_reg;
    logic [7:0]                 checksum_low_reg;
    logic [7:0]                 hold_reg;
    logic [cbr_pkg::ADDR_W-1:0] write_pointer_reg;
    logic [cbr_pkg::WIDX_W-1:0] drain_idx_reg;
    logic [cbr_pkg::DATA_W-1:0] rd_data_reg;
    logic [cbr_pkg::DATA_W-1:0] word_mem [cbr_pkg::WORDS];
    logic [cbr_pkg::WIDX_W-1:0] wr_word_idx;

    logic                       out_valid_reg;
    logic [1:0]                 reply_reg;
    logic                       write_valid_reg;
    logic [cbr_pkg::ADDR_W-1:0] write_address_reg;
    logic [cbr_pkg::DATA_W-1:0] write_data_reg;
    logic [1:0]                 status_reg;
    logic                       last_reg;

    assign wr_word_idx = cbr_pkg::WIDX_W'(byte_index_reg >> 1);

    always_comb
    begin
        stat.data_match = rx_byte == cfg.data_command;
        stat.stop_match = rx_byte == cfg.stop_command;
        stat.data_last  = byte_index_reg == cbr_pkg::IDX_W'(cbr_pkg::BLOCK_BYTES - 1);
        stat.ck_match   = {rx_byte, checksum_low_reg} == running_sum_reg;
        stat.drain_last = drain_idx_reg == cbr_pkg::WIDX_W'(cbr_pkg::WORDS - 1);
        stat.out_free   = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg    <= '0;
            running_sum_reg   <= '0;
            checksum_low_reg  <= '0;
            write_pointer_reg <= cbr_pkg::BASE_ADDRESS_RESET;
            drain_idx_reg     <= '0;
        end
        else if (cfg.rearm)
        begin
            byte_index_reg    <= '0;
            running_sum_reg   <= '0;
            checksum_low_reg  <= '0;
            write_pointer_reg <= cfg.base_address;
        end
        else
        begin
            if (cmd.open_block || cmd.close_block)
            begin
                byte_index_reg  <= '0;
                running_sum_reg <= '0;
            end
            else if (cmd.store_data)
            begin
                byte_index_reg  <= byte_index_reg + 1'b1;
                running_sum_reg <= running_sum_reg + {8'd0, rx_byte};
            end
            if (cmd.store_cklo)
                checksum_low_reg <= rx_byte;
            if (cmd.start_drain)
                drain_idx_reg <= '0;
            else if (cmd.emit_word)
            begin
                drain_idx_reg     <= drain_idx_reg + 1'b1;
                write_pointer_reg <= write_pointer_reg + 1'b1;
            end
        end
    end

    // Block buffer kept as words: the even byte waits in hold_reg for its partner.
    always_ff @(posedge clk)
    begin
        if (cmd.store_data && !byte_index_reg[0])
            hold_reg <= rx_byte;
        if (cmd.store_data && byte_index_reg[0])
            word_mem[wr_word_idx] <= {hold_reg, rx_byte};
        if (cmd.rd_en)
            rd_data_reg <= word_mem[drain_idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit_single || cmd.emit_word)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_single)
        begin
            reply_reg         <= cmd.single_reply;
            write_valid_reg   <= 1'b0;
            write_address_reg <= '0;
            write_data_reg    <= '0;
            status_reg        <= cmd.single_status;
            last_reg          <= 1'b1;
        end
        else if (cmd.emit_word)
        begin
            reply_reg         <= (drain_idx_reg == '0) ? cbr_pkg::REPLY_ACK
                                                       : cbr_pkg::REPLY_NONE;
            write_valid_reg   <= 1'b1;
            write_address_reg <= write_pointer_reg;
            write_data_reg    <= rd_data_reg;
            status_reg        <= cbr_pkg::STATUS_LOADING;
            last_reg          <= stat.drain_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign reply         = reply_reg;
    assign write_valid   = write_valid_reg;
    assign write_address = write_address_reg;
    assign write_data    = write_data_reg;
    assign status        = status_reg;
    assign last          = last_reg;

endmodule

### src/cbr_ctrl.sv
module cbr_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           rearm,
    input  logic           in_valid,
    output logic           in_ready,
    input  cbr_pkg::stat_t stat,
    output cbr_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_CMD,
        S_DATA,
        S_CKLO,
        S_CKHI,
        S_DONE_OK,
        S_DONE_ERR,
        S_DRAIN_RD,
        S_DRAIN_WR
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   take;

    always_comb
    begin
        in_ready = (state_reg != S_DRAIN_RD) && (state_reg != S_DRAIN_WR) && stat.out_free;
        take     = in_valid && in_ready;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.single_reply  = cbr_pkg::REPLY_NONE;
        cmd.single_status = cbr_pkg::STATUS_LOADING;
        unique case (state_reg)
            S_CMD:
            begin
                if (take)
                begin
                    cmd.emit_single = 1'b1;
                    if (stat.data_match)
                    begin
                        cmd.open_block = 1'b1;
                        state_next     = S_DATA;
                    end
                    else if (stat.stop_match)
                    begin
                        cmd.single_status = cbr_pkg::STATUS_OK;
                        state_next        = S_DONE_OK;
                    end
                    else
                    begin
                        cmd.single_status = cbr_pkg::STATUS_ERROR;
                        state_next        = S_DONE_ERR;
                    end
                end
            end
            S_DATA:
            begin
                if (take)
                begin
                    cmd.emit_single = 1'b1;
                    cmd.store_data  = 1'b1;
                    if (stat.data_last)
                        state_next = S_CKLO;
                end
            end
            S_CKLO:
            begin
                if (take)
                begin
                    cmd.emit_single = 1'b1;
                    cmd.store_cklo  = 1'b1;
                    state_next      = S_CKHI;
                end
            end
            S_CKHI:
            begin
                if (take)
                begin
                    cmd.close_block = 1'b1;
                    if (stat.ck_match)
                    begin
                        cmd.start_drain = 1'b1;
                        state_next      = S_DRAIN_RD;
                    end
                    else
                    begin
                        cmd.emit_single  = 1'b1;
                        cmd.single_reply = cbr_pkg::REPLY_NAK;
                        state_next       = S_CMD;
                    end
                end
            end
            S_DONE_OK:
            begin
                cmd.emit_single   = take;
                cmd.single_status = cbr_pkg::STATUS_OK;
            end
            S_DONE_ERR:
            begin
                cmd.emit_single   = take;
                cmd.single_status = cbr_pkg::STATUS_ERROR;
            end
            S_DRAIN_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_DRAIN_WR;
            end
            S_DRAIN_WR:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_word = 1'b1;
                    state_next    = stat.drain_last ? S_CMD : S_DRAIN_RD;
                end
            end
            default: state_next = S_CMD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CMD;
        else if (rearm)
            state_reg <= S_CMD;
        else
            state_reg <= state_next;
    end

endmodule

### src/checksummed_block_receiver.sv
// Checksummed block receiver. Link bytes come in one transaction at a time on
// the in channel. A data command byte opens a block of BLOCK_BYTES bytes,
// which are buffered and summed modulo 65536; a 16-bit checksum follows, low
// byte first. A matching checksum produces BLOCK_BYTES/2 result transactions,
// each a big-endian 16-bit word write to consecutive word addresses from the
// running write pointer, the first one carrying the ack reply and the final
// one carrying last. A mismatch produces a single nak transaction and the
// receiver waits for the next command. A stop command finishes the load with
// status OK, any other command finishes it with status error, and after that
// every byte just returns the held status. Every other byte produces exactly
// one result transaction with last set. Writing base_address over the APB
// port (byte address 0; data_command at 4, stop_command at 8) re-arms the
// receiver and aborts a partial block; configuration must be written only
// while the receiver is idle, a rule on the user that the block does not
// enforce. Throughput: a byte is taken whenever the output register is free,
// so ordinary bytes flow at one per cycle while it stays free. While a good
// block drains, no byte is taken; each word is first read from the block
// buffer into a register and then loaded into the output register, and a
// downstream stall holds the drain. The block buffer is a word-wide memory
// that is always fully written before it is read, so it needs no clearing
// after reset.
module checksummed_block_receiver (
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cbr_pkg::PADDR_W-1:0] paddr,
    input  logic [cbr_pkg::PDATA_W-1:0] pwdata,
    output logic [cbr_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,

    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [7:0]                  rx_byte,

    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  reply,
    output logic                        write_valid,
    output logic [cbr_pkg::ADDR_W-1:0]  write_address,
    output logic [cbr_pkg::DATA_W-1:0]  write_data,
    output logic [1:0]                  status,
    output logic                        last
);

    cbr_pkg::cfg_t  cfg;
    cbr_pkg::cmd_t  cmd;
    cbr_pkg::stat_t stat;

    // Configuration registers and the re-arm pulse.
    cbr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The controller tracks the protocol phase and sequences the drain of a
    // good block; it talks to the datapath only through cmd and stat.
    cbr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .rearm    (cfg.rearm),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the byte counter, checksum, block buffer, write
    // pointer and the output register.
    cbr_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .cmd           (cmd),
        .stat          (stat),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .reply         (reply),
        .write_valid   (write_valid),
        .write_address (write_address),
        .write_data    (write_data),
        .status        (status),
        .last          (last)
    );

endmodule

### dv/tb_checksummed_block_receiver.sv
module tb_checksummed_block_receiver;
    timeunit 1ns;
    timeprecision 1ps;

    // Link bytes to queue over the whole run, the directed part included.
    localparam int TOTAL_ITEMS    = 330;
    // Cycles with no transaction anywhere before the run is declared hung.
    // The slowest correct gap comes from result-side stalls or the settle time.
    localparam int WATCHDOG_LIMIT = 4000;
    // Cycles left after the last expected result so stray results show up.
    localparam int SETTLE_CYCLES  = 50;
    localparam int MAX_REPORTS    = 100;

    // Fill patterns for generated blocks.
    localparam int FILL_RANDOM   = 0;
    localparam int FILL_EXTREMES = 1;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;

    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [cbr_pkg::PADDR_W-1:0]  paddr = '0;
    logic [cbr_pkg::PDATA_W-1:0]  pwdata = '0;
    logic [cbr_pkg::PDATA_W-1:0]  prdata;
    logic                         pready;

    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic [7:0]                   rx_byte = 8'h00;

    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic [1:0]                   reply;
    logic                         write_valid;
    logic [cbr_pkg::ADDR_W-1:0]   write_address;
    logic [cbr_pkg::DATA_W-1:0]   write_data;
    logic [1:0]                   status;
    logic                         last;

    checksummed_block_receiver dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .reply         (reply),
        .write_valid   (write_valid),
        .write_address (write_address),
        .write_data    (write_data),
        .status        (status),
        .last          (last)
    );

    // One result transaction as the block should present it.
    typedef struct packed {
        logic [1:0]                 reply;
        logic                       wr;
        logic [cbr_pkg::ADDR_W-1:0] addr;
        logic [cbr_pkg::DATA_W-1:0] data;
        logic [1:0]                 stat;
        logic                       lst;
    } link_result_t;

    // Where the receiver stands in the link protocol.
    typedef enum logic [2:0] {
        RX_WAIT_CMD,
        RX_DATA,
        RX_CK_LO,
        RX_CK_HI,
        RX_DONE_OK,
        RX_DONE_ERR
    } rx_phase_t;

    // Link bytes waiting to be sent, and results still owed by the block.
    logic [7:0]   link_bytes[$];
    link_result_t owed_results[$];

    // The driver counts the bytes it presents, the scoreboard the bytes
    // that were taken; a byte is in flight while the two differ.
    int in_sent     = 0;
    int in_accepted = 0;

    int sender_idle_pct    = 33;
    int receiver_stall_pct = 33;
    int mismatches   = 0;
    int quiet_cycles = 0;
    int queued_bytes = 0;

    // Receiver model state. It shadows the register file and the protocol
    // engine, and is updated at the same clock edges as the hardware.
    logic [7:0]                 model_data_cmd = cbr_pkg::DATA_COMMAND_RESET;
    logic [7:0]                 model_stop_cmd = cbr_pkg::STOP_COMMAND_RESET;
    rx_phase_t                  rx_phase       = RX_WAIT_CMD;
    int unsigned                rx_count       = 0;
    logic [15:0]                rx_sum         = '0;
    logic [7:0]                 ck_low_byte    = '0;
    logic [7:0]                 block_store [cbr_pkg::BLOCK_BYTES];
    logic [cbr_pkg::ADDR_W-1:0] next_word_addr = cbr_pkg::BASE_ADDRESS_RESET;

    // What the stimulus side believes the command bytes are right now.
    logic [7:0] gen_data_cmd = cbr_pkg::DATA_COMMAND_RESET;
    logic [7:0] gen_stop_cmd = cbr_pkg::STOP_COMMAND_RESET;

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Receiver model
    // ------------------------------------------------------------------

    function automatic logic [1:0] load_status();
        case (rx_phase)
            RX_DONE_OK:  return cbr_pkg::STATUS_OK;
            RX_DONE_ERR: return cbr_pkg::STATUS_ERROR;
            default:     return cbr_pkg::STATUS_LOADING;
        endcase
    endfunction

    // The status field always reflects the phase after the byte is taken.
    task automatic owe_result(input logic [1:0] rep, input logic wr,
                              input logic [cbr_pkg::ADDR_W-1:0] addr,
                              input logic [cbr_pkg::DATA_W-1:0] data,
                              input logic lst);
        link_result_t r;
        r.reply = rep;
        r.wr    = wr;
        r.addr  = addr;
        r.data  = data;
        r.stat  = load_status();
        r.lst   = lst;
        owed_results.push_back(r);
    endtask

    // Writing the base address aborts whatever was in progress and reloads
    // the write pointer, even after the load had finished.
    task automatic model_register_write(input logic [cbr_pkg::PADDR_W-1:0] addr,
                                        input logic [cbr_pkg::PDATA_W-1:0] data);
        case (addr[3:2])
            cbr_pkg::REG_BASE_ADDRESS:
            begin
                rx_phase       = RX_WAIT_CMD;
                rx_count       = 0;
                rx_sum         = '0;
                ck_low_byte    = '0;
                next_word_addr = data[cbr_pkg::ADDR_W-1:0];
            end
            cbr_pkg::REG_DATA_COMMAND: model_data_cmd = data[7:0];
            cbr_pkg::REG_STOP_COMMAND: model_stop_cmd = data[7:0];
            default: ;
        endcase
    endtask

    // Works out every result that one accepted link byte causes.
    task automatic predict_link_byte(input logic [7:0] b);
        logic [15:0] ck;
        bit          drained;
        logic [1:0]  rep;
        rep     = cbr_pkg::REPLY_NONE;
        drained = 1'b0;
        case (rx_phase)
            RX_WAIT_CMD:
            begin
                // The data command wins when both commands are equal.
                if (b == model_data_cmd)
                begin
                    rx_phase = RX_DATA;
                    rx_count = 0;
                    rx_sum   = '0;
                end
                else if (b == model_stop_cmd)
                    rx_phase = RX_DONE_OK;
                else
                    rx_phase = RX_DONE_ERR;
            end
            RX_DATA:
            begin
                block_store[rx_count] = b;
                rx_sum   = rx_sum + 16'(b);
                rx_count = rx_count + 1;
                if (rx_count >= cbr_pkg::BLOCK_BYTES)
                    rx_phase = RX_CK_LO;
            end
            RX_CK_LO:
            begin
                ck_low_byte = b;
                rx_phase    = RX_CK_HI;
            end
            RX_CK_HI:
            begin
                ck       = {b, ck_low_byte};
                rx_phase = RX_WAIT_CMD;
                rx_count = 0;
                if (ck == rx_sum)
                begin
                    // Good block: one word write per byte pair, ack on the
                    // first, last on the final one, pointer wraps at 2^24.
                    for (int k = 0; k < cbr_pkg::WORDS; k++)
                    begin
                        owe_result((k == 0) ? cbr_pkg::REPLY_ACK : cbr_pkg::REPLY_NONE,
                                   1'b1, next_word_addr,
                                   {block_store[2*k], block_store[2*k+1]},
                                   k == cbr_pkg::WORDS - 1);
                        next_word_addr = next_word_addr + 1'b1;
                    end
                    drained = 1'b1;
                end
                else
                    rep = cbr_pkg::REPLY_NAK;
                rx_sum = '0;
            end
            default: ;  // Finished: the byte is ignored and status is held.
        endcase
        if (!drained)
            owe_result(rep, 1'b0, '0, '0, 1'b1);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < MAX_REPORTS)
            $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t",
                     what, got, want, $time);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Scoreboard and watchdog, sampled at the rising edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : scoreboard
        link_result_t want;
        bit           moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (psel && penable && pwrite && pready)
            begin
                model_register_write(paddr, pwdata);
                moved = 1'b1;
            end
            if (in_valid && in_ready)
            begin
                predict_link_byte(rx_byte);
                in_accepted++;
                moved = 1'b1;
            end
            if (out_valid && out_ready)
            begin
                moved = 1'b1;
                if (owed_results.size() == 0)
                    report_mismatch("result with nothing expected", 32'(reply),
                                    32'(cbr_pkg::REPLY_NONE));
                else
                begin
                    want = owed_results.pop_front();
                    if (reply !== want.reply)
                        report_mismatch("reply", 32'(reply), 32'(want.reply));
                    if (write_valid !== want.wr)
                        report_mismatch("write_valid", 32'(write_valid), 32'(want.wr));
                    if (write_address !== want.addr)
                        report_mismatch("write_address", 32'(write_address),
                                        32'(want.addr));
                    if (write_data !== want.data)
                        report_mismatch("write_data", 32'(write_data), 32'(want.data));
                    if (status !== want.stat)
                        report_mismatch("status", 32'(status), 32'(want.stat));
                    if (last !== want.lst)
                        report_mismatch("last", 32'(last), 32'(want.lst));
                end
            end
            // A hung block shows up as a long run of cycles with no
            // transaction on any port.
            if (moved)
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: presents queued link bytes and throttles the result side.
    // Everything changes at the falling edge so the rising edge sees
    // settled inputs.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            out_ready <= 1'b0;
        end
        else
        begin
            // A presented byte stays put until its transaction completes.
            if (in_sent == in_accepted)
            begin
                if (link_bytes.size() != 0
                    && int'($urandom_range(99)) >= sender_idle_pct)
                begin
                    rx_byte  <= link_bytes.pop_front();
                    in_valid <= 1'b1;
                    in_sent++;
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= (int'($urandom_range(99)) >= receiver_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Waits until every queued byte went in and every owed result came out.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (link_bytes.size() != 0 || in_sent != in_accepted
               || owed_results.size() != 0);
    endtask

    task automatic queue_byte(input logic [7:0] b);
        link_bytes.push_back(b);
        queued_bytes++;
    endtask

    // Setup cycle, then access cycle; the write lands at the rising edge
    // inside the access cycle since pready is always high.
    task automatic apb_write(input logic [cbr_pkg::PADDR_W-1:0] addr,
                             input logic [cbr_pkg::PDATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Writes the commands first and the base address last, which re-arms
    // the receiver with the new commands already in place.
    task automatic configure(input logic [cbr_pkg::ADDR_W-1:0] base,
                             input logic [7:0] dcmd, input logic [7:0] scmd);
        wait_idle();
        apb_write({cbr_pkg::REG_DATA_COMMAND, 2'b00}, cbr_pkg::PDATA_W'(dcmd));
        apb_write({cbr_pkg::REG_STOP_COMMAND, 2'b00}, cbr_pkg::PDATA_W'(scmd));
        apb_write({cbr_pkg::REG_BASE_ADDRESS, 2'b00}, cbr_pkg::PDATA_W'(base));
        gen_data_cmd = dcmd;
        gen_stop_cmd = scmd;
    endtask

    // Queues a complete block: command, data bytes, checksum low then high.
    // A corrupted block gets a checksum that differs in at least one bit.
    task automatic queue_block(input int fill, input bit corrupt);
        logic [15:0] sum;
        logic [7:0]  v;
        sum = '0;
        queue_byte(gen_data_cmd);
        for (int i = 0; i < cbr_pkg::BLOCK_BYTES; i++)
        begin
            if (fill == FILL_EXTREMES)
                v = (i % 2 == 0) ? 8'hFF : 8'h00;
            else
                v = 8'($urandom);
            queue_byte(v);
            sum = sum + 16'(v);
        end
        if (corrupt)
            sum = sum ^ 16'($urandom_range(1, 65535));
        queue_byte(sum[7:0]);
        queue_byte(sum[15:8]);
    endtask

    // A block cut short after cut_len bytes past the command.
    task automatic queue_partial_block(input int cut_len);
        queue_byte(gen_data_cmd);
        for (int i = 0; i < cut_len; i++)
            queue_byte(8'($urandom));
    endtask

    // A command byte that is neither the data nor the stop command.
    function automatic logic [7:0] bad_command();
        logic [7:0] v;
        do
            v = 8'($urandom);
        while (v == gen_data_cmd || v == gen_stop_cmd);
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin : main_sequence
        int         ending;
        logic [7:0] same_cmd;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // A block cut short on the reset configuration is aborted by a
        // re-arm near the top of the address space, so the good block that
        // follows starts from the new base and its word pointer wraps past
        // zero. Neither side idles during that block.
        queue_partial_block(20);
        configure(24'hFFFFF0, cbr_pkg::DATA_COMMAND_RESET, cbr_pkg::STOP_COMMAND_RESET);
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        queue_block(FILL_RANDOM, 1'b0);
        // The sender holds off until every owed result has come back.
        wait_idle();
        sender_idle_pct    = 33;
        receiver_stall_pct = 33;

        // A wrong checksum, then a stop and two bytes that are ignored.
        queue_block(FILL_EXTREMES, 1'b1);
        queue_byte(gen_stop_cmd);
        queue_byte(8'h00);
        queue_byte(8'hFF);

        // A write to an unmapped register has no effect on the receiver.
        wait_idle();
        apb_write(cbr_pkg::PADDR_W'(12), cbr_pkg::PDATA_W'($urandom));

        // With both commands on the same byte, that byte opens a block.
        same_cmd = 8'($urandom);
        configure(24'($urandom), same_cmd, same_cmd);
        queue_partial_block(5);

        // The extreme command values. An unknown command ends the load and
        // even a data command byte is ignored afterwards; the same holds
        // after a normal stop.
        configure(24'h000000, 8'h00, 8'hFF);
        queue_byte(bad_command());
        queue_byte(gen_data_cmd);
        configure(24'hFFFFFF, 8'hFF, 8'h00);
        queue_byte(gen_stop_cmd);
        queue_byte(8'hFF);

        // Short random phases until the byte budget is spent.
        while (queued_bytes < TOTAL_ITEMS)
        begin
            configure(24'($urandom), 8'($urandom), 8'($urandom));
            ending = int'($urandom_range(2));
            if (ending == 0)
                queue_byte(gen_stop_cmd);
            else if (ending == 1)
                queue_byte(bad_command());
            else
                queue_partial_block(int'($urandom_range(0, 12)));
            repeat ($urandom_range(3)) queue_byte(8'($urandom));
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
